@@ hdl/sync_length_frame_receiver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Sync length frame receiver: assertion macros
// Shared macros for the concurrent checks of the receiver.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define SLFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SLFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/slfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sync length frame receiver package
// Widths, sync constants and the controller state type.
// ----------------------------------------------------------------------------
package slfr_pkg;

   localparam int BYTE_W        = 8;
   localparam int MAX_FRAME_DEF = 64;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

endpackage

@@ hdl/slfr_if.sv @@
// ----------------------------------------------------------------------------
// Sync length frame receiver channels
// Valid/ready channels for received bytes and for emitted frame bytes.
// ----------------------------------------------------------------------------
interface slfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [slfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [slfr_pkg::BYTE_W-1:0]  frame_byte;
   logic                         frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

@@ hdl/sync_length_frame_receiver_unit.sv @@
// A completed frame is read from the frame memory one byte at a time: each byte
// is first read into the read register, then loaded into the output register,
// which waits while the output side stalls. No byte is taken while a frame is
// read out. Throughput: one byte per cycle while gathering; readout is set by
// the single read port. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// Sync length frame receiver
// Gathers bytes into a frame memory, checks the A5/5A sync word, and emits
// the whole frame once the length byte's payload has arrived.
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_unit_defines.svh"

module sync_length_frame_receiver_unit #(
   parameter int MAX_FRAME = slfr_pkg::MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   slfr_req_if.sink    req_ch,
   slfr_rsp_if.source  rsp_ch
);

   localparam int ADDR_W = $clog2(MAX_FRAME);
   localparam int CNT_W  = $clog2(MAX_FRAME + 1);
   localparam int BW     = slfr_pkg::BYTE_W;

   logic [BW-1:0] frame_mem [MAX_FRAME];

   slfr_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BW-1:0]     len_ff, len_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] last_ptr_ff, last_ptr_in;
   logic [BW-1:0]     rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]     rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_take;
   logic              rd_en;
   logic              load_en;
   logic              at_last;
   logic [CNT_W-1:0]  n_inc;
   logic              sync_bad;
   logic [BW-1:0]     len_sel;
   logic              complete;

   // Byte bookkeeping for an accepted item
   always_comb begin
      n_inc    = count_ff + CNT_W'(1);
      sync_bad = ((n_inc == CNT_W'(1)) && (req_ch.rx_byte != slfr_pkg::SYNC_FIRST)) ||
                 ((n_inc == CNT_W'(2)) && (req_ch.rx_byte != slfr_pkg::SYNC_SECOND));
      // The length byte is the item itself on the third byte
      len_sel  = (n_inc == CNT_W'(3)) ? req_ch.rx_byte : len_ff;
      complete = !sync_bad && (n_inc >= CNT_W'(3)) &&
                 (len_sel == BW'(n_inc - CNT_W'(3)));
   end

   // Controller outputs
   always_comb begin
      req_take = 1'b0;
      rd_en    = 1'b0;
      load_en  = 1'b0;
      case (state_ff)
         slfr_pkg::ST_IDLE: begin
            req_take = req_ch.valid;
         end
         slfr_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         slfr_pkg::ST_LOAD: begin
            load_en = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            req_take = 1'b0;
         end
      endcase
   end

   assign at_last = (rd_ptr_ff == last_ptr_ff);

   // Controller next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slfr_pkg::ST_IDLE: begin
            if (req_take && complete) begin
               state_in = slfr_pkg::ST_READ;
            end
         end
         slfr_pkg::ST_READ: begin
            state_in = slfr_pkg::ST_LOAD;
         end
         slfr_pkg::ST_LOAD: begin
            if (load_en) begin
               state_in = at_last ? slfr_pkg::ST_IDLE : slfr_pkg::ST_READ;
            end
         end
         default: begin
            state_in = slfr_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      count_in     = count_ff;
      len_in       = len_ff;
      rd_ptr_in    = rd_ptr_ff;
      last_ptr_in  = last_ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_take) begin
         if (n_inc == CNT_W'(3)) begin
            len_in = req_ch.rx_byte;
         end
         if (complete) begin
            count_in    = '0;
            rd_ptr_in   = '0;
            last_ptr_in = ADDR_W'(n_inc - CNT_W'(1));
         end else if (sync_bad || (n_inc == CNT_W'(MAX_FRAME))) begin
            // drop the gathered bytes
            count_in = '0;
         end else begin
            count_in = n_inc;
         end
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_en) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = rd_data_ff;
         rsp_last_in  = at_last;
         if (!at_last) begin
            rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slfr_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rd_ptr_ff   <= rd_ptr_in;
      last_ptr_ff <= last_ptr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Frame memory: written while gathering, read only during readout
   always_ff @(posedge clock) begin
      if (req_take) begin
         frame_mem[count_ff[ADDR_W-1:0]] <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_ptr_ff];
      end
   end

   assign req_ch.ready      = (state_ff == slfr_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.frame_byte = rsp_byte_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   `SLFR_ASSERT(a_count_range, clock, reset, count_ff < CNT_W'(MAX_FRAME), "byte count out of range")
   `SLFR_ASSERT(a_count_clear_in_readout, clock, reset, (state_ff != slfr_pkg::ST_IDLE) |-> (count_ff == '0), "count not cleared during readout")
   `SLFR_ASSERT(a_ptr_bound, clock, reset, (state_ff != slfr_pkg::ST_IDLE) |-> (rd_ptr_ff <= last_ptr_ff), "read pointer past frame end")
   `SLFR_ASSERT(a_last_ends_readout, clock, reset, (load_en && at_last) |=> (state_ff == slfr_pkg::ST_IDLE) && rsp_ch.frame_last, "readout did not end on last byte")

endmodule

@@ tb/sync_length_frame_receiver_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync length frame receiver testbench
// Sends received bytes through a bursty source and checks each emitted frame
// byte and its last flag. The expected bytes come from a behavioral deframer
// kept in step with the accepted bytes. A short directed table covers the
// sync errors and the zero length frame, then a full size frame and an
// oversize frame. Random traffic follows: short well-formed frames with
// random payload, with noise and broken sync words mixed in. The output side
// stalls in patterns.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_unit_tb;

   localparam int BYTE_W       = slfr_pkg::BYTE_W;
   localparam int MAX_FRAME    = slfr_pkg::MAX_FRAME_DEF;
   localparam int RANDOM_BYTES = 20;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = slfr_pkg::SYNC_FIRST;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = slfr_pkg::SYNC_SECOND;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_beat_type;

   typedef struct {
      logic [BYTE_W-1:0] rx;
      bit                known;
      int                n_out;
   } directed_row_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_RUNS
   } ready_mode_type;

   logic clock;
   logic reset;

   slfr_req_if req_bus();
   slfr_rsp_if rsp_bus();

   sync_length_frame_receiver_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Deframer state and the frame bytes still owed by the block.
   logic [BYTE_W-1:0] gather_mem [MAX_FRAME];
   logic [6:0]        gathered;
   frame_beat_type    frame_beats_due [$];
   int                errors;
   int                bytes_sent;
   int                burst_left;

   // Take one byte into the deframer; queue the frame bytes it releases.
   function automatic int deframe_byte(input logic [BYTE_W-1:0] b);
      int             n;
      int             released;
      frame_beat_type beat;
      released = 0;
      n = int'(gathered);
      if (n >= MAX_FRAME) n = 0;
      gather_mem[n] = b;
      n++;
      if (n == 1 && b != SYNC_FIRST) n = 0;
      if (n == 2 && b != SYNC_SECOND) n = 0;
      if (n >= 3 && int'(gather_mem[2]) == n - 3) begin
         for (int k = 0; k < n; k++) begin
            beat.data = gather_mem[k];
            beat.last = (k + 1 == n);
            frame_beats_due.push_back(beat);
         end
         released = n;
         n = 0;
      end
      if (n >= MAX_FRAME) n = 0;
      gathered = n[6:0];
      return released;
   endfunction

   // Present one byte, hold it until taken, then maybe pause between bursts.
   task automatic send_byte(input logic [BYTE_W-1:0] b, output int released);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      released = deframe_byte(b);
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      end
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] len, input int payload);
      int released;
      send_byte(SYNC_FIRST, released);
      send_byte(SYNC_SECOND, released);
      send_byte(len, released);
      for (int i = 0; i < payload; i++) begin
         case ($urandom_range(0, 9))
            0:       send_byte(8'h00, released);
            1:       send_byte(8'hFF, released);
            default: send_byte(BYTE_W'($urandom), released);
         endcase
      end
   endtask

   directed_row_type directed_rows [20] = '{
      '{8'h00,       1, 0},   // junk right after reset
      '{8'hFF,       1, 0},
      '{SYNC_FIRST,  1, 0},
      '{8'h00,       1, 0},   // bad second sync byte
      '{SYNC_FIRST,  1, 0},
      '{SYNC_FIRST,  1, 0},   // bad second byte is not a new first byte
      '{SYNC_SECOND, 1, 0},
      '{SYNC_FIRST,  1, 0},
      '{SYNC_SECOND, 1, 0},
      '{8'h00,       1, 3},   // zero length frame
      '{SYNC_FIRST,  1, 0},
      '{SYNC_SECOND, 1, 0},
      '{8'h01,       1, 0},
      '{8'hFF,       1, 4},
      '{SYNC_FIRST,  1, 0},
      '{SYNC_SECOND, 1, 0},
      '{8'h02,       0, 0},
      '{8'h00,       0, 0},
      '{8'h80,       0, 0},
      '{8'hFF,       0, 0}    // stray byte after the frame
   };

   // Output side: stall in one of a few patterns, switching every so often.
   ready_mode_type ready_mode;
   int             mode_left;
   int             run_left;
   logic           run_level;

   always @(posedge clock) begin
      frame_beat_type beat;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode_left = 0;
         run_left  = 0;
         run_level = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frame_beats_due.size() == 0) begin
               $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                        $time, rsp_bus.frame_byte, rsp_bus.frame_last);
               errors++;
            end else begin
               beat = frame_beats_due.pop_front();
               if (rsp_bus.frame_byte !== beat.data) begin
                  $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                           $time, beat.data, rsp_bus.frame_byte);
                  errors++;
               end
               if (rsp_bus.frame_last !== beat.last) begin
                  $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                           $time, beat.last, rsp_bus.frame_last);
                  errors++;
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left  = 100;
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_bus.ready <= 1'b1;
            RDY_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (run_left == 0) begin
                  run_level = ~run_level;
                  run_left  = $urandom_range(1, 20);
               end else begin
                  run_left--;
               end
               rsp_bus.ready <= run_level;
            end
         endcase
      end
   end

   initial begin
      int released;
      int start_count;
      int pick;
      int n;
      logic [BYTE_W-1:0] b;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      gathered        = '0;
      errors          = 0;
      bytes_sent      = 0;
      burst_left      = $urandom_range(1, 16);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx, released);
         if (directed_rows[i].known && released != directed_rows[i].n_out) begin
            $display("%0t: frame size mismatch on byte %0d: expected %0d, actual %0d",
                     $time, i, directed_rows[i].n_out, released);
            errors++;
         end
      end

      // Largest frame that still completes, then an oversize frame that drops.
      send_frame(8'd61, 61);
      send_frame(8'd62, 61);

      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(0, 12);
            send_frame(BYTE_W'(n), n);
         end else if (pick < 85) begin
            // broken sync word
            send_byte(SYNC_FIRST, released);
            b = BYTE_W'($urandom);
            if (b == SYNC_SECOND) b = ~b;
            send_byte(b, released);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               b = BYTE_W'($urandom);
               if (b == SYNC_FIRST && $urandom_range(0, 1)) b = ~b;
               send_byte(b, released);
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (frame_beats_due.size() != 0) @(posedge clock);
      repeat (2 * MAX_FRAME + 20) @(posedge clock);
      if (errors == 0) begin
         $display("sync_length_frame_receiver_unit test passed");
      end else begin
         $display("sync_length_frame_receiver_unit test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout with %0d frame bytes outstanding", $time,
               frame_beats_due.size());
      $display("sync_length_frame_receiver_unit test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/slfr_pkg.sv
hdl/slfr_if.sv
hdl/sync_length_frame_receiver_unit.sv
tb/sync_length_frame_receiver_unit_tb.sv
